### rtl/rttt_pkg.sv
// shared types and constants for the request tag tracker
package rttt_pkg;

   localparam int SLOTS = 32;
   localparam int SLOT_W = $clog2(SLOTS);

   localparam logic [2:0] MODE_ALLOC = 3'd0;
   localparam logic [2:0] MODE_ARM = 3'd1;
   localparam logic [2:0] MODE_COMPLETE = 3'd2;
   localparam logic [2:0] MODE_FREE = 3'd3;
   localparam logic [2:0] MODE_TICK = 3'd4;
   localparam logic [2:0] MODE_CONN_RESET = 3'd5;

   localparam logic [2:0] KIND_GRANTED = 3'd0;
   localparam logic [2:0] KIND_FULL = 3'd1;
   localparam logic [2:0] KIND_OK = 3'd2;
   localparam logic [2:0] KIND_STALE = 3'd3;
   localparam logic [2:0] KIND_TIMED_OUT = 3'd4;
   localparam logic [2:0] KIND_CONN_RESET = 3'd5;
   localparam logic [2:0] KIND_DONE = 3'd6;

   localparam logic [7:0] TIMEOUT_MAX = 8'd180;
   localparam logic [31:0] STATUS_TIMED_OUT = 32'd110;
   localparam logic [31:0] STATUS_CONN_RESET = 32'd104;

   localparam logic CSR_SCAN_INTERVAL = 1'b0;
   localparam logic CSR_SEQUENCE_SEED = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic       load;      // capture request fields
      logic       op_single; // do the one-slot operation, emit result
      logic       gate;      // evaluate tick gating
      logic       scan_clr;  // reset scan index
      logic       scan_step; // examine one slot, maybe emit
      logic       emit_done; // emit done result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic run;       // scan is to run
      logic scan_last; // scan index at final slot
      logic hit;       // current scan slot expires
   } sts_type;

endpackage

### rtl/rttt_dp.sv
// datapath: slot table, counters and result register
module rttt_dp import rttt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [31:0]        csr_data,
   input  logic [2:0]         req_mode,
   input  logic [4:0]         req_slot_index,
   input  logic [31:0]        req_tag,
   input  logic [31:0]        req_time_now,
   input  logic [7:0]         req_timeout_secs,
   input  logic [31:0]        req_conn_id,
   input  logic signed [31:0] req_reply_status,
   output logic [2:0]         o_kind,
   output logic [4:0]         o_slot,
   output logic [31:0]        o_tag,
   output logic [31:0]        o_conn,
   output logic signed [31:0] o_status,
   output logic               o_last
);

   logic [SLOTS-1:0]  busy_ff, armed_ff;
   logic [31:0]       tag_ff [SLOTS];
   logic [31:0]       prev_ff [SLOTS];
   logic [31:0]       dl_ff [SLOTS];
   logic [31:0]       conn_ff [SLOTS];
   logic [SLOT_W-1:0] cur_ff, scan_ff;
   logic [31:0]       seq_ff, scan_time_ff;
   logic [7:0]        intv_ff;

   logic [2:0]  m_ff;
   logic [4:0]  s_ff;
   logic [31:0] t_ff, now_ff, cid_ff, rep_ff;
   logic [7:0]  tmo_ff;
   logic        run_ff;

   // alloc search: first free slot at or after cursor
   logic              found;
   logic [SLOT_W-1:0] pick;
   always_comb begin
      logic [SLOT_W:0] c;
      found = 1'b0;
      pick = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         c = {1'b0, cur_ff} + (SLOT_W+1)'(i);
         if (c >= (SLOT_W+1)'(SLOTS)) c = c - (SLOT_W+1)'(SLOTS);
         if (!busy_ff[c[SLOT_W-1:0]]) begin
            found = 1'b1;
            pick = c[SLOT_W-1:0];
         end
      end
   end

   logic [31:0] seq1, seqn;
   assign seq1 = seq_ff + 32'd1;
   assign seqn = (seq1 == prev_ff[pick]) ? seq1 + 32'd1 : seq1;

   logic              in_range, match;
   logic [SLOT_W-1:0] si;
   assign in_range = ({1'b0, s_ff} < 6'(SLOTS));
   assign si = s_ff[SLOT_W-1:0];
   assign match = in_range && busy_ff[si] && (tag_ff[si] == t_ff);

   logic [7:0]  tmo_c;
   logic [31:0] diff;
   assign tmo_c = (tmo_ff > TIMEOUT_MAX) ? TIMEOUT_MAX : tmo_ff;
   assign diff = now_ff - scan_time_ff;

   logic hit;
   assign hit = busy_ff[scan_ff] && armed_ff[scan_ff] &&
      ((m_ff == MODE_TICK) ? (now_ff > dl_ff[scan_ff]) : (conn_ff[scan_ff] == cid_ff));
   assign sts.run = run_ff;
   assign sts.scan_last = (scan_ff == SLOT_W'(SLOTS - 1));
   assign sts.hit = hit;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         armed_ff <= '0;
         cur_ff <= '0;
         seq_ff <= '0;
         scan_time_ff <= '0;
         intv_ff <= 8'd1;
         run_ff <= 1'b0;
         scan_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            tag_ff[i] <= '0;
            prev_ff[i] <= '0;
            dl_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_SCAN_INTERVAL) intv_ff <= csr_data[7:0];
            else seq_ff <= csr_data;
         end
         if (cmd.gate) begin
            if (m_ff == MODE_CONN_RESET) run_ff <= 1'b1;
            else if (now_ff < scan_time_ff) begin
               scan_time_ff <= now_ff;
               run_ff <= 1'b0;
            end else if (diff > {24'd0, intv_ff}) begin
               scan_time_ff <= now_ff;
               run_ff <= 1'b1;
            end else run_ff <= 1'b0;
         end
         if (cmd.scan_clr) scan_ff <= '0;
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + SLOT_W'(1);
            if (hit) begin
               prev_ff[scan_ff] <= tag_ff[scan_ff];
               tag_ff[scan_ff] <= '0;
               dl_ff[scan_ff] <= '0;
               armed_ff[scan_ff] <= 1'b0;
               busy_ff[scan_ff] <= 1'b0;
            end
         end
         if (cmd.op_single) begin
            if (m_ff == MODE_ALLOC) begin
               if (found) begin
                  cur_ff <= (pick == SLOT_W'(SLOTS - 1)) ? '0 : pick + SLOT_W'(1);
                  seq_ff <= seqn;
                  busy_ff[pick] <= 1'b1;
                  armed_ff[pick] <= 1'b0;
                  tag_ff[pick] <= seqn;
               end
            end else if (match) begin
               if (m_ff == MODE_ARM) begin
                  dl_ff[si] <= now_ff + {24'd0, tmo_c};
                  armed_ff[si] <= 1'b1;
               end else begin
                  prev_ff[si] <= tag_ff[si];
                  tag_ff[si] <= '0;
                  dl_ff[si] <= '0;
                  armed_ff[si] <= 1'b0;
                  busy_ff[si] <= 1'b0;
               end
            end
         end
      end
   end

   // request capture and connection store
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff <= req_mode;
         s_ff <= req_slot_index;
         t_ff <= req_tag;
         now_ff <= req_time_now;
         tmo_ff <= req_timeout_secs;
         cid_ff <= req_conn_id;
         rep_ff <= req_reply_status;
      end
      if (cmd.op_single && m_ff == MODE_ARM && match) conn_ff[si] <= cid_ff;
   end

   // result register, loaded only when a result is emitted
   always_ff @(posedge clock) begin
      if (cmd.op_single) begin
         o_conn <= '0;
         o_last <= 1'b1;
         if (m_ff == MODE_ALLOC) begin
            o_kind <= found ? KIND_GRANTED : KIND_FULL;
            o_slot <= found ? 5'(pick) : 5'd0;
            o_tag <= found ? seqn : 32'd0;
            o_status <= '0;
         end else if (!match) begin
            o_kind <= KIND_STALE;
            o_slot <= s_ff;
            o_tag <= t_ff;
            o_status <= '0;
         end else begin
            o_kind <= KIND_OK;
            o_slot <= s_ff;
            o_tag <= t_ff;
            o_status <= (m_ff == MODE_COMPLETE) ? rep_ff : 32'sd0;
         end
      end else if (cmd.scan_step && hit) begin
         o_kind <= (m_ff == MODE_TICK) ? KIND_TIMED_OUT : KIND_CONN_RESET;
         o_slot <= 5'(scan_ff);
         o_tag <= tag_ff[scan_ff];
         o_conn <= conn_ff[scan_ff];
         o_status <= (m_ff == MODE_TICK) ? STATUS_TIMED_OUT : STATUS_CONN_RESET;
         o_last <= 1'b0;
      end else if (cmd.emit_done) begin
         o_kind <= KIND_DONE;
         o_slot <= '0;
         o_tag <= '0;
         o_conn <= '0;
         o_status <= '0;
         o_last <= 1'b1;
      end
   end

endmodule

### rtl/rttt_ctrl.sv
// controller: sequences single-slot ops, scans and result handoff
module rttt_ctrl import rttt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_GATE = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [2:0] mode_ff;
   logic       free;

   assign rsp_valid = valid_ff;
   assign free = !valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_mode == MODE_TICK || req_mode == MODE_CONN_RESET) ? ST_GATE
                  : (req_mode > MODE_CONN_RESET) ? ST_DONE : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (free) begin
               cmd.op_single = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_GATE: begin
            cmd.gate = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.run) state_in = ST_DONE;
            else if (!sts.hit || free) begin
               cmd.scan_step = 1'b1;
               if (sts.hit) valid_in = 1'b1;
               if (sts.scan_last) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (free) begin
               cmd.emit_done = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         mode_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (cmd.load) mode_ff <= req_mode;
      end
   end

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.op_single, cmd.scan_step, cmd.emit_done}))
      else $error("more than one command");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(cmd.op_single || cmd.emit_done ||
      (cmd.scan_step && sts.hit)))
      else $error("result overwritten while stalled");
   a_scan_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (mode_ff == MODE_TICK || mode_ff == MODE_CONN_RESET))
      else $error("scan in wrong mode");
`endif

endmodule

### rtl/request_tag_tracker_with_timeout_unit.sv
// top level of the request tag tracker with timeout
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | mode, slot, tag, time, timeout, conn, status
//  rsp     | out       | rsp_valid/rsp_stall  | kind, slot, tag, close conn, status, last
//  csr     | in        | csr_valid/csr_ready  | index, data
// allocate, arm, complete, free: each request is captured, then does its slot table op.
// tick and connection reset: capture, gate, then one slot examined per cycle while no hit
// waits on a stalled result, then done; a tick that the scan interval gates off skips the scan.
// reset clears busy/armed bits, tags, deadlines, cursor and counters at once.
// a stalled result holds off the next result until taken; requests are taken only when idle.
module request_tag_tracker_with_timeout_unit import rttt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [4:0]         req_slot_index,
   input  logic [31:0]        req_tag,
   input  logic [31:0]        req_time_now,
   input  logic [7:0]         req_timeout_secs,
   input  logic [31:0]        req_conn_id,
   input  logic signed [31:0] req_reply_status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [4:0]         rsp_out_slot,
   output logic [31:0]        rsp_out_tag,
   output logic [31:0]        rsp_close_conn,
   output logic signed [31:0] rsp_delivered_status,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rttt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_mode,
      .rsp_stall, .rsp_valid, .sts, .cmd
   );

   rttt_dp u_dp (
      .clock, .reset, .cmd, .sts, .csr_valid, .csr_index, .csr_data,
      .req_mode, .req_slot_index, .req_tag, .req_time_now, .req_timeout_secs,
      .req_conn_id, .req_reply_status,
      .o_kind(rsp_kind), .o_slot(rsp_out_slot), .o_tag(rsp_out_tag),
      .o_conn(rsp_close_conn), .o_status(rsp_delivered_status), .o_last(rsp_last)
   );

endmodule

### tb/sv/tb_request_tag_tracker_with_timeout_unit.sv
// testbench for the request tag tracker: random requests checked against a local predictor
`timescale 1ns / 1ps

module tb_request_tag_tracker_with_timeout_unit;
   import rttt_pkg::*;

   typedef struct packed {
      logic [2:0]         mode;
      logic [4:0]         slot_index;
      logic [31:0]        tag;
      logic [31:0]        time_now;
      logic [7:0]         timeout_secs;
      logic [31:0]        conn_id;
      logic signed [31:0] reply_status;
   } request_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [4:0]         out_slot;
      logic [31:0]        out_tag;
      logic [31:0]        close_conn;
      logic signed [31:0] delivered_status;
      logic               last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_mode = '0;
   logic [4:0] req_slot_index = '0;
   logic [31:0] req_tag = '0;
   logic [31:0] req_time_now = '0;
   logic [7:0] req_timeout_secs = '0;
   logic [31:0] req_conn_id = '0;
   logic signed [31:0] req_reply_status = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_kind;
   logic [4:0] rsp_out_slot;
   logic [31:0] rsp_out_tag;
   logic [31:0] rsp_close_conn;
   logic signed [31:0] rsp_delivered_status;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   request_tag_tracker_with_timeout_unit dut (.*);

   // clock, period 12 ns
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the slot table
   logic        tbl_busy [SLOTS];
   logic        tbl_armed [SLOTS];
   logic [31:0] tbl_tag [SLOTS];
   logic [31:0] tbl_prev [SLOTS];
   logic [31:0] tbl_deadline [SLOTS];
   logic [31:0] tbl_conn [SLOTS];
   logic [4:0]  cursor;
   logic [31:0] seq_count;
   logic [31:0] scan_stamp;
   logic [7:0]  scan_gap;

   request_type pending_requests[$];
   result_type  expected_results[$];
   int errors = 0;
   int results_seen = 0;
   int requests_sent = 0;
   int cycle_count = 0;
   int kind_count [8];

   // tags the stimulus may reuse
   logic [31:0] known_tag [SLOTS];
   logic [31:0] next_time = 32'd1000;

   function automatic result_type mk(logic [2:0] k, logic [4:0] s, logic [31:0] t,
                                     logic [31:0] c, logic [31:0] st);
      result_type r;
      r.kind = k; r.out_slot = s; r.out_tag = t; r.close_conn = c;
      r.delivered_status = st; r.last = 1'b0;
      return r;
   endfunction

   function automatic void free_slot(int s);
      tbl_prev[s] = tbl_tag[s];
      tbl_tag[s] = '0;
      tbl_deadline[s] = '0;
      tbl_armed[s] = 1'b0;
      tbl_busy[s] = 1'b0;
   endfunction

   // compute results of one request and update the table
   function automatic void predict_tracker(request_type rq);
      result_type out[$];
      bit found;
      bit run;
      int c;
      logic [7:0] tmo;
      if (rq.mode == MODE_ALLOC) begin
         found = 0;
         for (int i = 0; i < SLOTS && !found; i++) begin
            c = (cursor + i) % SLOTS;
            if (!tbl_busy[c]) begin
               found = 1;
               cursor = 5'((c + 1) % SLOTS);
               seq_count = seq_count + 1;
               if (seq_count == tbl_prev[c]) seq_count = seq_count + 1;
               tbl_busy[c] = 1'b1;
               tbl_armed[c] = 1'b0;
               tbl_tag[c] = seq_count;
               known_tag[c] = seq_count;
               out.push_back(mk(KIND_GRANTED, 5'(c), seq_count, 0, 0));
            end
         end
         if (!found) out.push_back(mk(KIND_FULL, 0, 0, 0, 0));
      end else if (rq.mode inside {MODE_ARM, MODE_COMPLETE, MODE_FREE}) begin
         if (!(tbl_busy[rq.slot_index] && tbl_tag[rq.slot_index] == rq.tag)) begin
            out.push_back(mk(KIND_STALE, rq.slot_index, rq.tag, 0, 0));
         end else if (rq.mode == MODE_ARM) begin
            tmo = (rq.timeout_secs > TIMEOUT_MAX) ? TIMEOUT_MAX : rq.timeout_secs;
            tbl_deadline[rq.slot_index] = rq.time_now + {24'd0, tmo};
            tbl_conn[rq.slot_index] = rq.conn_id;
            tbl_armed[rq.slot_index] = 1'b1;
            out.push_back(mk(KIND_OK, rq.slot_index, rq.tag, 0, 0));
         end else begin
            out.push_back(mk(KIND_OK, rq.slot_index, rq.tag, 0,
                             rq.mode == MODE_COMPLETE ? rq.reply_status : 0));
            free_slot(rq.slot_index);
         end
      end else if (rq.mode == MODE_TICK || rq.mode == MODE_CONN_RESET) begin
         run = 1;
         if (rq.mode == MODE_TICK) begin
            if (rq.time_now < scan_stamp) begin
               scan_stamp = rq.time_now;
               run = 0;
            end else if (rq.time_now - scan_stamp > scan_gap) begin
               scan_stamp = rq.time_now;
            end else begin
               run = 0;
            end
         end
         for (int i = 0; run && i < SLOTS; i++) begin
            if (tbl_busy[i] && tbl_armed[i]) begin
               if (rq.mode == MODE_TICK && rq.time_now > tbl_deadline[i]) begin
                  out.push_back(mk(KIND_TIMED_OUT, 5'(i), tbl_tag[i], tbl_conn[i],
                                   STATUS_TIMED_OUT));
                  free_slot(i);
               end else if (rq.mode == MODE_CONN_RESET && tbl_conn[i] == rq.conn_id) begin
                  out.push_back(mk(KIND_CONN_RESET, 5'(i), tbl_tag[i], tbl_conn[i],
                                   STATUS_CONN_RESET));
                  free_slot(i);
               end
            end
         end
         out.push_back(mk(KIND_DONE, 0, 0, 0, 0));
      end else begin
         out.push_back(mk(KIND_DONE, 0, 0, 0, 0));
      end
      out[out.size() - 1].last = 1'b1;
      foreach (out[i]) expected_results.push_back(out[i]);
   endfunction

   // driver: bursts with random gaps
   int gap_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_tracker({req_mode, req_slot_index, req_tag, req_time_now,
                             req_timeout_secs, req_conn_id, req_reply_status});
            requests_sent++;
         end
         if (req_valid && req_stall) begin
            // hold stalled request
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_valid <= 1'b1;
            {req_mode, req_slot_index, req_tag, req_time_now, req_timeout_secs,
             req_conn_id, req_reply_status} <= rq;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            result_type got, exp_r;
            got = {rsp_kind, rsp_out_slot, rsp_out_tag, rsp_close_conn,
                   rsp_delivered_status, rsp_last};
            results_seen++;
            kind_count[rsp_kind]++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected kind %0d slot %0d tag %h conn %h st %0d last %b",
                           $time, exp_r.kind, exp_r.out_slot, exp_r.out_tag,
                           exp_r.close_conn, exp_r.delivered_status, exp_r.last);
                  $display("%0t:          actual kind %0d slot %0d tag %h conn %h st %0d last %b",
                           $time, got.kind, got.out_slot, got.out_tag,
                           got.close_conn, got.delivered_status, got.last);
                  errors++;
               end
            end
         end
         // stall windows alternate with free-running stretches
         stall_phase = (stall_phase + 1) % 200;
         if (stall_phase < 60) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push(logic [2:0] m, int s, logic [31:0] t, logic [31:0] now,
                       logic [7:0] tmo, logic [31:0] conn, logic [31:0] st);
      request_type r;
      r.mode = m; r.slot_index = 5'(s); r.tag = t; r.time_now = now;
      r.timeout_secs = tmo; r.conn_id = conn; r.reply_status = st;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (SLOTS + 10) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] d);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCAN_INTERVAL) scan_gap = d[7:0];
      else seq_count = d;
      csr_valid <= 1'b0;
   endtask

   // predicted tag for a slot, or a random one
   function automatic logic [31:0] pick_tag(int s);
      return ($urandom_range(0, 7) == 0) ? $urandom() : known_tag[s];
   endfunction

   // random phase: well-formed lifecycles plus noise
   task automatic random_batch(int n, logic [31:0] conn_base);
      int s;
      int m;
      for (int k = 0; k < n; k++) begin
         s = $urandom_range(0, 31);
         m = $urandom_range(0, 99);
         next_time = next_time + $urandom_range(0, 40);
         if (m < 30) push(MODE_ALLOC, $urandom_range(0, 31), $urandom(), $urandom(),
                          8'($urandom()), $urandom(), $urandom());
         else if (m < 55) push(MODE_ARM, s, pick_tag(s), next_time,
                               8'($urandom_range(0, 255)),
                               conn_base + $urandom_range(0, 3), $urandom());
         else if (m < 67) push(MODE_COMPLETE, s, pick_tag(s), next_time, 8'($urandom()),
                               $urandom(), $urandom());
         else if (m < 77) push(MODE_FREE, s, pick_tag(s), next_time, 8'($urandom()),
                               $urandom(), $urandom());
         else if (m < 89) push(MODE_TICK, s, $urandom(),
                               ($urandom_range(0, 15) == 0) ? $urandom() : next_time,
                               8'($urandom()), $urandom(), $urandom());
         else if (m < 97) push(MODE_CONN_RESET, s, $urandom(), $urandom(), 8'($urandom()),
                               conn_base + $urandom_range(0, 4), $urandom());
         else push(3'($urandom_range(6, 7)), s, $urandom(), $urandom(), 8'($urandom()),
                   $urandom(), $urandom());
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_busy[i] = 0; tbl_armed[i] = 0; tbl_tag[i] = 0; tbl_prev[i] = 0;
         tbl_deadline[i] = 0; tbl_conn[i] = 0; known_tag[i] = 0;
      end
      cursor = 0; seq_count = 0; scan_stamp = 0; scan_gap = 8'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: tag skip around the seed, wrap of the counter
      csr_write(CSR_SEQUENCE_SEED, 32'hFFFF_FFFE);
      push(MODE_ALLOC, 0, 0, 0, 0, 0, 0);
      push(MODE_ALLOC, 0, 0, 0, 0, 0, 0);
      drain();
      push(MODE_ARM, 0, known_tag[0], 32'hFFFF_FFF0, 8'hFF, 32'hFFFF_FFFF, 0);
      push(MODE_ARM, 1, known_tag[1], 32'd0, 8'd0, 32'd7, 0);
      push(MODE_ARM, 2, 32'd5, 0, 0, 0, 0);
      push(MODE_COMPLETE, 1, known_tag[1], 0, 0, 0, 32'sh8000_0000);
      push(MODE_FREE, 0, known_tag[0] ^ 1, 0, 0, 0, 0);
      push(MODE_FREE, 0, known_tag[0], 0, 0, 0, 0);
      push(MODE_ALLOC, 0, 0, 0, 0, 0, 0);
      push(MODE_COMPLETE, 2, known_tag[2], 0, 0, 0, 32'sh7FFF_FFFF);
      push(MODE_TICK, 0, 0, 32'd0, 0, 0, 0);
      push(MODE_TICK, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
      push(MODE_TICK, 0, 0, 32'd5, 0, 0, 0);
      push(MODE_CONN_RESET, 31, 32'hFFFF_FFFF, 0, 0, 32'h0, 0);
      push(MODE_CONN_RESET, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
      push(3'd6, 0, 0, 0, 0, 0, 0);
      push(3'd7, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, -1);
      drain();

      // fill the table to reach full, then arm all and expire them
      csr_write(CSR_SCAN_INTERVAL, 8'd0);
      csr_write(CSR_SEQUENCE_SEED, 32'd0);
      for (int i = 0; i < SLOTS + 1; i++) push(MODE_ALLOC, 0, 0, 0, 0, 0, 0);
      drain();
      for (int i = 0; i < SLOTS; i++)
         push(MODE_ARM, i, known_tag[i], 32'd100, 8'(i), 32'd9, 0);
      push(MODE_TICK, 0, 0, 32'd500, 0, 0, 0);
      drain();

      // random phases with different settings
      next_time = 32'd1000;
      csr_write(CSR_SCAN_INTERVAL, 8'd255);
      csr_write(CSR_SEQUENCE_SEED, $urandom());
      random_batch(50, 32'hA000_0000);
      drain();
      csr_write(CSR_SCAN_INTERVAL, 8'd3);
      csr_write(CSR_SEQUENCE_SEED, 32'hFFFF_FFFF);
      random_batch(50, 32'hFFFF_FFFC);
      drain();
      csr_write(CSR_SCAN_INTERVAL, 8'd0);
      random_batch(50, 32'd0);
      drain();

      $display("requests %0d results %0d: granted %0d full %0d ok %0d stale %0d",
               requests_sent, results_seen, kind_count[0], kind_count[1],
               kind_count[2], kind_count[3]);
      $display("timed out %0d conn reset %0d done %0d",
               kind_count[4], kind_count[5], kind_count[6]);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
